[src/three_band_biquad_equalizer_defines.svh]
// Assertion macros for the three-band biquad equalizer.
// Expects signals named clock and reset in the scope where a macro is used.
`ifndef THREE_BAND_BIQUAD_EQUALIZER_DEFINES_SVH
`define THREE_BAND_BIQUAD_EQUALIZER_DEFINES_SVH

// Property checked on every rising clock edge, ignored while reset is high.
`define TBBQ_ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Property checked on every rising clock edge, reset included.
`define TBBQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[src/tbbq_pkg.sv]
// Shared types and constants for the three-band biquad equalizer.
// No dependencies; imported by the CSR interface and every module.
package tbbq_pkg;

   // Coefficient format: 32-bit two's complement.
   localparam int COEF_BITS     = 32;
   // Guard bits kept above the sample width in the filter history.
   localparam int GUARD_BITS    = 4;
   // Products per biquad section: x, x1, x2, y1, y2.
   localparam int TAPS          = 5;
   localparam int NUM_COEFS     = 15;
   localparam int COEF_IDX_BITS = 4;
   localparam int STEP_BITS     = 3;
   localparam int HIST_WORDS    = 4;

   // Configuration port geometry.
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 64;

   // Raw pattern of 1.0 in Q2.30, the reset value of every b0.
   localparam logic [COEF_BITS-1:0] COEF_UNITY = 32'h4000_0000;

   typedef logic signed [COEF_BITS-1:0] coef_type;
   typedef logic [COEF_IDX_BITS-1:0]    coef_idx_type;
   typedef logic [STEP_BITS-1:0]        step_type;
   typedef logic [1:0]                  hist_word_type;

   // History word positions within one channel and band.
   localparam hist_word_type HW_X1 = 2'd0;
   localparam hist_word_type HW_X2 = 2'd1;
   localparam hist_word_type HW_Y1 = 2'd2;
   localparam hist_word_type HW_Y2 = 2'd3;

   // Controls from the sequencer to the multiply-accumulate unit.
   typedef struct packed {
      logic mul_en;
      logic acc_clear;
      logic acc_en;
   } mac_ctrl_type;

   // Reset value of coefficient k: b0 of each band is unity, all else zero.
   function automatic coef_type coef_reset_value(input int k);
      return (k % TAPS == 0) ? coef_type'(COEF_UNITY) : coef_type'(0);
   endfunction

endpackage

[src/tbbq_req_if.sv]
// Input item channel of the equalizer: valid/ready with channel and sample.
// Standalone; the width follows SAMPLE_BITS.
interface tbbq_req_if #(parameter int SAMPLE_BITS = 24) ();
   logic                          valid;
   logic                          ready;
   logic                          channel;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output channel, output sample_in, input ready);
   modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

[src/tbbq_rsp_if.sv]
// Result item channel of the equalizer: valid/ready with channel and sample.
// Standalone; the width follows SAMPLE_BITS.
interface tbbq_rsp_if #(parameter int SAMPLE_BITS = 24) ();
   logic                          valid;
   logic                          ready;
   logic                          channel_out;
   logic signed [SAMPLE_BITS-1:0] sample_out;

   modport source (output valid, output channel_out, output sample_out, input ready);
   modport sink   (input valid, input channel_out, input sample_out, output ready);
endinterface

[src/tbbq_csr_if.sv]
// Configuration write channel: valid/ready with register index and data.
// Depends on tbbq_pkg for the index and data widths.
interface tbbq_csr_if import tbbq_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

[src/tbbq_coef_regs.sv]
// Coefficient register file: fifteen Q2.30 coefficients, two per write.
// Depends on tbbq_pkg.
module tbbq_coef_regs import tbbq_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [CSR_INDEX_BITS-1:0] wr_index,
   input  logic [CSR_DATA_BITS-1:0]  wr_data,
   input  coef_idx_type              rd_sel,
   output coef_type                  rd_coef
);

   coef_type coef_ff [NUM_COEFS];
   coef_type coef_in [NUM_COEFS];

   // Register i holds coefficient 2i in its low half and 2i+1 in its high half.
   // The last register has only a low half; indexes past the list match nothing.
   always_comb begin
      for (int k = 0; k < NUM_COEFS; k++) begin
         coef_in[k] = coef_ff[k];
         if (wr_en && (wr_index == CSR_INDEX_BITS'(k >> 1))) begin
            if (k[0]) begin
               coef_in[k] = coef_type'(wr_data[CSR_DATA_BITS-1:COEF_BITS]);
            end else begin
               coef_in[k] = coef_type'(wr_data[COEF_BITS-1:0]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COEFS; k++) begin
            coef_ff[k] <= coef_reset_value(k);
         end
      end else begin
         coef_ff <= coef_in;
      end
   end

   // Read port for the multiplier.
   assign rd_coef = (rd_sel < COEF_IDX_BITS'(NUM_COEFS)) ? coef_ff[rd_sel] : '0;

endmodule

[src/tbbq_hist.sv]
// Filter history store: x1, x2, y1, y2 for every channel and band.
// Depends on tbbq_pkg.
module tbbq_hist import tbbq_pkg::*; #(
   parameter int CHANNELS  = 2,
   parameter int BANDS     = 3,
   parameter int HIST_BITS = 28,
   localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
   localparam int BAND_BITS = (BANDS > 1) ? $clog2(BANDS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [CH_BITS-1:0]          chan,
   input  logic [BAND_BITS-1:0]        band,
   input  hist_word_type               rd_word_sel,
   output logic signed [HIST_BITS-1:0] rd_word,
   input  logic                        wr_en,
   input  logic signed [HIST_BITS-1:0] wr_x,
   input  logic signed [HIST_BITS-1:0] wr_y
);

   logic signed [HIST_BITS-1:0] hist_ff [CHANNELS][BANDS][HIST_WORDS];
   logic signed [HIST_BITS-1:0] hist_in [CHANNELS][BANDS][HIST_WORDS];

   // At the end of a band, shift the input and output delay lines by one.
   always_comb begin
      hist_in = hist_ff;
      if (wr_en) begin
         hist_in[chan][band][HW_X2] = hist_ff[chan][band][HW_X1];
         hist_in[chan][band][HW_X1] = wr_x;
         hist_in[chan][band][HW_Y2] = hist_ff[chan][band][HW_Y1];
         hist_in[chan][band][HW_Y1] = wr_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '{default: '0};
      end else begin
         hist_ff <= hist_in;
      end
   end

   assign rd_word = hist_ff[chan][band][rd_word_sel];

endmodule

[src/tbbq_mac.sv]
// Shared multiply-accumulate unit with rounding and saturation of a band output.
// Depends on tbbq_pkg for the coefficient type and the control struct.
module tbbq_mac import tbbq_pkg::*; #(
   parameter int HIST_BITS      = 28,
   parameter int COEF_FRAC_BITS = 30
) (
   input  logic                        clock,
   input  mac_ctrl_type                ctrl,
   input  logic signed [HIST_BITS-1:0] operand,
   input  coef_type                    coef,
   output logic signed [HIST_BITS-1:0] band_y
);

   localparam int PROD_BITS = HIST_BITS + COEF_BITS;
   // Five products need three more bits.
   localparam int ACC_BITS  = PROD_BITS + 3;
   localparam int TOP_LSB   = COEF_FRAC_BITS + HIST_BITS - 1;
   localparam logic [ACC_BITS-1:0]  ROUND_HALF = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
   localparam logic [HIST_BITS-1:0] HIST_MAX   = {1'b0, {(HIST_BITS-1){1'b1}}};
   localparam logic [HIST_BITS-1:0] HIST_MIN   = {1'b1, {(HIST_BITS-1){1'b0}}};

   logic signed [PROD_BITS-1:0] product_ff;
   logic signed [PROD_BITS-1:0] product_in;
   logic signed [PROD_BITS-1:0] mult_w;
   logic [ACC_BITS-1:0]         acc_ff;
   logic [ACC_BITS-1:0]         acc_in;
   logic [ACC_BITS-1:0]         sum_w;
   logic [ACC_BITS-TOP_LSB-1:0] top_bits_w;
   logic                        in_range_w;

   // Multiplier stage.
   assign mult_w     = operand * coef;
   assign product_in = ctrl.mul_en ? mult_w : product_ff;

   // Accumulator starts at one half LSB of the result so the final shift rounds.
   assign sum_w  = acc_ff + {{(ACC_BITS-PROD_BITS){product_ff[PROD_BITS-1]}}, product_ff};
   assign acc_in = ctrl.acc_clear ? ROUND_HALF : (ctrl.acc_en ? sum_w : acc_ff);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
      acc_ff     <= acc_in;
   end

   // Floor shift by the fraction width, then clamp to the history width.
   assign top_bits_w = sum_w[ACC_BITS-1:TOP_LSB];
   assign in_range_w = (&top_bits_w) || !(|top_bits_w);
   assign band_y     = in_range_w ? signed'(sum_w[TOP_LSB:COEF_FRAC_BITS])
                                  : signed'(sum_w[ACC_BITS-1] ? HIST_MIN : HIST_MAX);

endmodule

[src/three_band_biquad_equalizer.sv]
// Three-band equalizer: each sample runs through bass, mid and treble Direct
// Form I biquads in turn, with a separate history per channel and band. One
// multiply-accumulate unit does all the work, five products per band plus a
// final step to round, clamp and update the history. A new item is taken only
// while the sequencer is idle, once the last one has gone to the output
// register. A finished result sits in an output register, so the next item is
// accepted while it waits. Coefficient writes are always accepted and belong
// only in idle time; reset clears the history and sets every band to a unity
// pass-through.
`include "three_band_biquad_equalizer_defines.svh"

module three_band_biquad_equalizer import tbbq_pkg::*; #(
   parameter int CHANNELS       = 2,
   parameter int BANDS          = 3,
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 30
) (
   input logic        clock,
   input logic        reset,
   tbbq_req_if.sink   req_ch,
   tbbq_rsp_if.source rsp_ch,
   tbbq_csr_if.sink   csr_ch
);

   localparam int HIST_BITS = SAMPLE_BITS + GUARD_BITS;
   localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int BAND_BITS = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]                  state_ff, state_in;
   step_type                    step_ff, step_in;
   logic [BAND_BITS-1:0]        band_ff, band_in;
   logic                        chan_ff, chan_in;
   logic signed [HIST_BITS-1:0] x_ff, x_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_chan_ff, rsp_chan_in;
   logic [SAMPLE_BITS-1:0]      rsp_sample_ff, rsp_sample_in;

   logic                        req_fire;
   logic                        rsp_free;
   logic                        band_done;
   logic                        band_last;
   logic [CH_BITS-1:0]          chan_idx;
   coef_idx_type                coef_sel;
   coef_type                    coef_w;
   hist_word_type               word_sel;
   logic signed [HIST_BITS-1:0] hist_word_w;
   logic signed [HIST_BITS-1:0] operand_w;
   logic signed [HIST_BITS-1:0] band_y_w;
   logic [GUARD_BITS:0]         x_top_bits;
   logic [SAMPLE_BITS-1:0]      sample_sat_w;
   mac_ctrl_type                mac_ctrl;
   logic                        run_start_w;

   // Handshakes.
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // Coefficients.
   tbbq_coef_regs u_coef (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid && csr_ch.ready),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.wdata),
      .rd_sel   (coef_sel),
      .rd_coef  (coef_w)
   );

   // Channel index wraps at the channel count; the echoed tag does not.
   assign chan_idx = (CHANNELS > 1) ? CH_BITS'(chan_ff) : '0;
   assign word_sel = hist_word_type'(step_ff - STEP_BITS'(1));
   assign coef_sel = coef_idx_type'(int'(band_ff) * TAPS + int'(step_ff));

   tbbq_hist #(
      .CHANNELS  (CHANNELS),
      .BANDS     (BANDS),
      .HIST_BITS (HIST_BITS)
   ) u_hist (
      .clock       (clock),
      .reset       (reset),
      .chan        (chan_idx),
      .band        (band_ff),
      .rd_word_sel (word_sel),
      .rd_word     (hist_word_w),
      .wr_en       (band_done),
      .wr_x        (x_ff),
      .wr_y        (band_y_w)
   );

   // Tap 0 multiplies the band input, taps 1 to 4 the stored history.
   assign operand_w = (step_ff == '0) ? x_ff : hist_word_w;

   always_comb begin
      mac_ctrl.mul_en    = (state_ff == ST_RUN) && (step_ff < STEP_BITS'(TAPS));
      mac_ctrl.acc_clear = (state_ff == ST_RUN) && (step_ff == '0);
      mac_ctrl.acc_en    = (state_ff == ST_RUN) && (step_ff != '0)
                           && (step_ff < STEP_BITS'(TAPS));
   end

   tbbq_mac #(
      .HIST_BITS      (HIST_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac (
      .clock   (clock),
      .ctrl    (mac_ctrl),
      .operand (operand_w),
      .coef    (coef_w),
      .band_y  (band_y_w)
   );

   assign band_done = (state_ff == ST_RUN) && (step_ff == STEP_BITS'(TAPS));
   assign band_last = (band_ff == BAND_BITS'(BANDS - 1));

   // Final clamp of the last band output to the sample width.
   assign x_top_bits   = x_ff[HIST_BITS-1:SAMPLE_BITS-1];
   assign sample_sat_w = ((&x_top_bits) || !(|x_top_bits)) ? x_ff[SAMPLE_BITS-1:0]
                       : (x_ff[HIST_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX);

   // Sequencer: band by band, six steps each, then hand off to the output register.
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      band_in       = band_ff;
      chan_in       = chan_ff;
      x_in          = x_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_chan_in   = rsp_chan_ff;
      rsp_sample_in = rsp_sample_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               x_in     = {{GUARD_BITS{req_ch.sample_in[SAMPLE_BITS-1]}}, req_ch.sample_in};
               chan_in  = req_ch.channel;
               step_in  = '0;
               band_in  = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (band_done) begin
               x_in    = band_y_w;
               step_in = '0;
               if (band_last) begin
                  state_in = ST_FIN;
               end else begin
                  band_in = band_ff + BAND_BITS'(1);
               end
            end else begin
               step_in = step_ff + STEP_BITS'(1);
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_chan_in   = chan_ff;
               rsp_sample_in = sample_sat_w;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         band_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         band_ff      <= band_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff       <= chan_in;
      x_ff          <= x_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.channel_out = rsp_chan_ff;
   assign rsp_ch.sample_out  = signed'(rsp_sample_ff);

   // Sequencer sits at the first tap of the first band.
   assign run_start_w = (state_ff == ST_RUN) && (step_ff == '0) && (band_ff == '0);

   // An accepted item starts at the first tap of the first band.
   `TBBQ_ASSERT_RUN(a_start_clean, req_fire |=> run_start_w, "item did not start at band zero")
   // The step counter never runs past the rounding step.
   `TBBQ_ASSERT_RUN(a_step_bound, state_ff == ST_RUN |-> step_ff <= STEP_BITS'(TAPS), "step overrun")
   // A result appears only out of the finishing state.
   `TBBQ_ASSERT_RUN(a_rsp_source, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FIN, "stray result")
   // Reset leaves the block idle with no result pending.
   `TBBQ_ASSERT_ALWAYS(a_reset_idle, reset |=> state_ff == ST_IDLE && !rsp_valid_ff, "reset not idle")

endmodule
